// ===== rtl/tis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tis_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int Q_W        = 32;
  localparam int SQRT_CELLS = 64;
  localparam int DIV_CELLS  = 32;
  localparam int MAG_W      = 66;

  localparam logic [30:0] SPEED_RESET = 31'(1 << FRAC_BITS);

  localparam logic [1:0] OUTCOME_ROOT    = 2'd0;
  localparam logic [1:0] OUTCOME_CLOSEST = 2'd1;
  localparam logic [1:0] OUTCOME_DEGEN   = 2'd2;
  localparam logic [1:0] OUTCOME_UNUSED  = 2'd3;

  typedef enum logic [1:0] {SEL_ZERO, SEL_A, SEL_B, SEL_MIN} sel_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } geom_t;

  typedef struct packed {
    geom_t              g;
    logic signed [64:0] a;
    logic signed [64:0] b;
    logic [63:0]        c;
    logic               dpos;
  } sq_side_t;

  typedef struct packed {
    logic [127:0] x;
    logic [65:0]  rem;
    logic [63:0]  root;
  } sq_lane_t;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [Q_W-1:0]   num_lo;
    logic [MAG_W-1:0] den;
    logic [Q_W-1:0]   q;
  } div_lane_t;

  typedef struct packed {
    geom_t      g;
    sel_t       sel;
    logic [1:0] outcome;
    logic       zero_a;
    logic       ovf_a;
    logic       zero_b;
    logic       ovf_b;
  } div_side_t;

endpackage

`default_nettype wire

// ===== rtl/tis_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tis_sqrt_cell import tis_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire sq_lane_t in_lane,
  input  wire sq_side_t in_side,
  output logic      out_valid,
  output sq_lane_t  out_lane,
  output sq_side_t  out_side
);

  logic [67:0] rem_sh;
  logic [67:0] trial;
  logic [67:0] diff;
  logic        ge;
  sq_lane_t    lane_next;

  always_comb begin
    rem_sh = {in_lane.rem, in_lane.x[127:126]};
    trial  = {2'b00, in_lane.root, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
    lane_next.x    = {in_lane.x[125:0], 2'b00};
    lane_next.rem  = ge ? diff[65:0] : rem_sh[65:0];
    lane_next.root = {in_lane.root[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_lane <= lane_next;
    out_side <= in_side;
  end

endmodule

`default_nettype wire

// ===== rtl/tis_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tis_div_cell import tis_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire div_lane_t in_a,
  input  wire div_lane_t in_b,
  input  wire div_side_t in_side,
  output logic       out_valid,
  output div_lane_t  out_a,
  output div_lane_t  out_b,
  output div_side_t  out_side
);

  function automatic div_lane_t div_step(input div_lane_t l);
    logic [MAG_W:0] rem_sh;
    logic [MAG_W:0] den_x;
    logic [MAG_W:0] diff;
    logic           ge;
    div_lane_t      r;
    rem_sh   = {l.rem, l.num_lo[Q_W-1]};
    den_x    = {1'b0, l.den};
    diff     = rem_sh - den_x;
    ge       = (rem_sh >= den_x);
    r.rem    = ge ? diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];
    r.num_lo = {l.num_lo[Q_W-2:0], 1'b0};
    r.den    = l.den;
    r.q      = {l.q[Q_W-2:0], ge};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_a    <= div_step(in_a);
    out_b    <= div_step(in_b);
    out_side <= in_side;
  end

endmodule

`default_nettype wire

// ===== rtl/target_intercept_solver.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Data
// input     start, busy          rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y
// config    cfg_valid, cfg_ready cfg_data (projectile speed)
// result    done                 aim_x, aim_y, hit_time, outcome
//
// A new word is taken every cycle; busy stays low and cfg_ready stays high.
// Each result passes through the 64-cell square root chain and the 32-cell
// divider chain plus eleven other stages.
// Reset is synchronous, clears the valid bits of the pipeline and sets the
// projectile speed to 1.0.
// The receiver cannot stall; done is a one-cycle strobe.

module target_intercept_solver import tis_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] rel_pos_x,
  input  wire logic signed [31:0] rel_pos_y,
  input  wire logic signed [31:0] rel_vel_x,
  input  wire logic signed [31:0] rel_vel_y,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [30:0]        cfg_data,
  output logic                    done,
  output logic signed [31:0]      aim_x,
  output logic signed [31:0]      aim_y,
  output logic [31:0]             hit_time,
  output logic [1:0]              outcome
);

  logic [30:0] speed;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= SPEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      speed <= cfg_data;
    end
  end

  // Stage 1: products.
  logic               v1;
  geom_t              g1;
  logic signed [63:0] vvx, vvy, pvx, pvy, ppx, ppy;
  logic [61:0]        ss;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    g1  <= '{rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y};
    vvx <= rel_vel_x * rel_vel_x;
    vvy <= rel_vel_y * rel_vel_y;
    pvx <= rel_pos_x * rel_vel_x;
    pvy <= rel_pos_y * rel_vel_y;
    ppx <= rel_pos_x * rel_pos_x;
    ppy <= rel_pos_y * rel_pos_y;
    ss  <= {31'd0, speed} * {31'd0, speed};
  end

  // Stage 2: a, b, c.
  logic     v2;
  sq_side_t s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2.g    <= g1;
    s2.a    <= {vvx[63], vvx} + {vvy[63], vvy} - {3'b000, ss};
    s2.b    <= {pvx[63], pvx} + {pvy[63], pvy};
    s2.c    <= {1'b0, ppx[62:0]} + {1'b0, ppy[62:0]};
    s2.dpos <= 1'b0;
  end

  // Stage 3: partial products of b*b and |a|*c.
  logic        v3;
  sq_side_t    s3;
  logic [64:0] mag_b2, mag_a2;
  logic [63:0] bb00, bb01, bb11, ac00, ac01, ac10, ac11;

  always_comb begin
    mag_b2 = s2.b[64] ? (65'd0 - s2.b) : s2.b;
    mag_a2 = s2.a[64] ? (65'd0 - s2.a) : s2.a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3   <= s2;
    bb00 <= mag_b2[31:0] * mag_b2[31:0];
    bb01 <= mag_b2[31:0] * mag_b2[63:32];
    bb11 <= mag_b2[63:32] * mag_b2[63:32];
    ac00 <= mag_a2[31:0] * s2.c[31:0];
    ac01 <= mag_a2[31:0] * s2.c[63:32];
    ac10 <= mag_a2[63:32] * s2.c[31:0];
    ac11 <= mag_a2[63:32] * s2.c[63:32];
  end

  // Stage 4: full products.
  logic         v4;
  sq_side_t     s4;
  logic [127:0] bb4, ac4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    s4  <= s3;
    bb4 <= 128'(bb00) + (128'(bb01) << 33) + (128'(bb11) << 64);
    ac4 <= 128'(ac00) + (128'(ac01) << 32) + (128'(ac10) << 32) + (128'(ac11) << 64);
  end

  // Stage 5: discriminant, loaded into the root chain.
  logic [128:0] sac, d5;
  logic         dpos5;
  sq_side_t     side5;
  sq_lane_t     lane5;

  always_comb begin
    sac   = s4.a[64] ? (129'd0 - {1'b0, ac4}) : {1'b0, ac4};
    d5    = {1'b0, bb4} - sac;
    dpos5 = !d5[128] && (d5 != 129'd0);
    side5 = s4;
    side5.dpos = dpos5;
    lane5.x    = dpos5 ? d5[127:0] : 128'd0;
    lane5.rem  = 66'd0;
    lane5.root = 64'd0;
  end

  logic     sq_v    [SQRT_CELLS+1];
  sq_lane_t sq_lane [SQRT_CELLS+1];
  sq_side_t sq_side [SQRT_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else begin
      sq_v[0] <= v4;
    end
    sq_lane[0] <= lane5;
    sq_side[0] <= side5;
  end

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    tis_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sq_v[i]),
      .in_lane  (sq_lane[i]),
      .in_side  (sq_side[i]),
      .out_valid(sq_v[i+1]),
      .out_lane (sq_lane[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  // Stage F: f and the choice of quotients.
  sq_side_t           sf;
  logic [63:0]        root_f;
  logic signed [66:0] b_x, r_x, f_c;
  logic               bpos, azero, czero;
  logic signed [66:0] na_c, da_c, nb_c, db_c;
  sel_t               sel_c;
  logic [1:0]         oc_c;

  always_comb begin
    sf     = sq_side[SQRT_CELLS];
    root_f = sq_lane[SQRT_CELLS].root;
    b_x    = {{2{sf.b[64]}}, sf.b};
    r_x    = {3'b000, root_f};
    bpos   = !sf.b[64] && (sf.b != 65'd0);
    f_c    = bpos ? (67'd0 - (b_x + r_x)) : (r_x - b_x);
    azero  = (sf.a == 65'd0);
    czero  = (sf.c == 64'd0);
    nb_c   = {3'b000, sf.c};
    db_c   = f_c;
    da_c   = {{2{sf.a[64]}}, sf.a};
    if (!sf.dpos) begin
      na_c  = 67'd0 - b_x;
      sel_c = azero ? SEL_ZERO : SEL_A;
      oc_c  = azero ? OUTCOME_DEGEN : OUTCOME_CLOSEST;
    end else begin
      na_c = f_c;
      oc_c = OUTCOME_ROOT;
      if (azero || (f_c[66] != sf.a[64])) begin
        sel_c = SEL_B;
      end else if (czero || f_c[66]) begin
        sel_c = SEL_A;
      end else begin
        sel_c = SEL_MIN;
      end
    end
  end

  logic               vf;
  geom_t              gf;
  sel_t               self;
  logic [1:0]         ocf;
  logic signed [66:0] naf, daf, nbf, dbf;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else begin
      vf <= sq_v[SQRT_CELLS];
    end
    gf   <= sf.g;
    self <= sel_c;
    ocf  <= oc_c;
    naf  <= na_c;
    daf  <= da_c;
    nbf  <= nb_c;
    dbf  <= db_c;
  end

  // Stage G: magnitudes and signs.
  logic [66:0]      abs_na, abs_da, abs_nb, abs_db;
  logic             vg;
  div_side_t        sg;
  logic [MAG_W-1:0] mna, mda, mnb, mdb;

  always_comb begin
    abs_na = naf[66] ? (67'd0 - naf) : naf;
    abs_da = daf[66] ? (67'd0 - daf) : daf;
    abs_nb = nbf[66] ? (67'd0 - nbf) : nbf;
    abs_db = dbf[66] ? (67'd0 - dbf) : dbf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else begin
      vg <= vf;
    end
    mna       <= abs_na[MAG_W-1:0];
    mda       <= abs_da[MAG_W-1:0];
    mnb       <= abs_nb[MAG_W-1:0];
    mdb       <= abs_db[MAG_W-1:0];
    sg.g      <= gf;
    sg.sel    <= self;
    sg.outcome <= ocf;
    sg.zero_a <= (naf[66] != daf[66]) || (daf == 67'd0);
    sg.zero_b <= (nbf[66] != dbf[66]) || (dbf == 67'd0);
    sg.ovf_a  <= 1'b0;
    sg.ovf_b  <= 1'b0;
  end

  // Stage H: overflow test and divider load.
  div_lane_t la_h, lb_h;
  div_side_t sh;

  always_comb begin
    la_h.rem    = MAG_W'(mna >> (Q_W - FRAC_BITS));
    la_h.num_lo = Q_W'(mna << FRAC_BITS);
    la_h.den    = mda;
    la_h.q      = '0;
    lb_h.rem    = MAG_W'(mnb >> (Q_W - FRAC_BITS));
    lb_h.num_lo = Q_W'(mnb << FRAC_BITS);
    lb_h.den    = mdb;
    lb_h.q      = '0;
    sh          = sg;
    sh.ovf_a    = (la_h.rem >= mda);
    sh.ovf_b    = (lb_h.rem >= mdb);
  end

  logic      dv   [DIV_CELLS+1];
  div_lane_t dla  [DIV_CELLS+1];
  div_lane_t dlb  [DIV_CELLS+1];
  div_side_t dsd  [DIV_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= vg;
    end
    dla[0] <= la_h;
    dlb[0] <= lb_h;
    dsd[0] <= sh;
  end

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    tis_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv[j]),
      .in_a     (dla[j]),
      .in_b     (dlb[j]),
      .in_side  (dsd[j]),
      .out_valid(dv[j+1]),
      .out_a    (dla[j+1]),
      .out_b    (dlb[j+1]),
      .out_side (dsd[j+1])
    );
  end

  // Stage T: time select.
  div_side_t   st;
  logic [31:0] qa, qb, t_c;

  always_comb begin
    st = dsd[DIV_CELLS];
    qa = st.zero_a ? 32'd0 : (st.ovf_a ? 32'hFFFF_FFFF : dla[DIV_CELLS].q);
    qb = st.zero_b ? 32'd0 : (st.ovf_b ? 32'hFFFF_FFFF : dlb[DIV_CELLS].q);
    case (st.sel)
      SEL_ZERO: t_c = 32'd0;
      SEL_A:    t_c = qa;
      SEL_B:    t_c = qb;
      SEL_MIN:  t_c = (qb < qa) ? qb : qa;
      default:  t_c = 32'd0;
    endcase
  end

  logic        vt;
  geom_t       gt;
  logic [31:0] tq_t;
  logic [1:0]  oc_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else begin
      vt <= dv[DIV_CELLS];
    end
    gt   <= st.g;
    tq_t <= t_c;
    oc_t <= st.outcome;
  end

  // Stage M: t * v.
  logic               vm;
  logic signed [31:0] px_m, py_m;
  logic signed [64:0] prod_x, prod_y;
  logic [31:0]        tq_m;
  logic [1:0]         oc_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else begin
      vm <= vt;
    end
    prod_x <= $signed({1'b0, tq_t}) * gt.vx;
    prod_y <= $signed({1'b0, tq_t}) * gt.vy;
    px_m   <= gt.px;
    py_m   <= gt.py;
    tq_m   <= tq_t;
    oc_m   <= oc_t;
  end

  // Output stage: shift, add and saturate.
  logic signed [49:0] sum_x, sum_y;
  logic signed [31:0] sat_x, sat_y;

  always_comb begin
    sum_x = 50'(prod_x >>> FRAC_BITS) + 50'(px_m);
    sum_y = 50'(prod_y >>> FRAC_BITS) + 50'(py_m);
    if (sum_x[49:31] == {19{sum_x[49]}}) begin
      sat_x = sum_x[31:0];
    end else begin
      sat_x = sum_x[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    if (sum_y[49:31] == {19{sum_y[49]}}) begin
      sat_y = sum_y[31:0];
    end else begin
      sat_y = sum_y[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vm;
    end
    aim_x    <= sat_x;
    aim_y    <= sat_y;
    hit_time <= tq_m;
    outcome  <= oc_m;
  end

`ifndef ASSERT_OFF
  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (outcome != OUTCOME_UNUSED))
    else $error("reserved outcome code on a result word");

  a_degen_time: assert property (@(posedge clk) disable iff (rst)
    (done && (outcome == OUTCOME_DEGEN)) |-> (hit_time == 32'd0))
    else $error("degenerate result with nonzero time");

  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

  a_zero_sel: assert property (@(posedge clk) disable iff (rst)
    (vt && (oc_t == OUTCOME_DEGEN)) |-> (tq_t == 32'd0))
    else $error("degenerate case picked a quotient");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_target_intercept_solver.sv =====
`timescale 1ns / 1ps

module tb_target_intercept_solver;
  import tis_pkg::*;

  typedef logic signed [255:0] big_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } query_t;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [31:0]        t;
    logic [1:0]         oc;
  } answer_t;

  logic clk, rst, start, busy, cfg_valid, cfg_ready, done;
  logic signed [31:0] rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y;
  logic [30:0] cfg_data;
  logic signed [31:0] aim_x, aim_y;
  logic [31:0] hit_time;
  logic [1:0] outcome;

  target_intercept_solver dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .rel_pos_x(rel_pos_x), .rel_pos_y(rel_pos_y),
    .rel_vel_x(rel_vel_x), .rel_vel_y(rel_vel_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .aim_x(aim_x), .aim_y(aim_y), .hit_time(hit_time),
    .outcome(outcome)
  );

  query_t  pending_queries[$];
  answer_t expected_answers[$];
  logic [30:0] shot_speed;
  int idle_pct;
  int errors;
  int accepted;
  int checked;
  int cnt_root, cnt_closest, cnt_degen;

  function automatic big_t floor_sqrt(big_t x);
    big_t r, c;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (big_t'(1) << i);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic big_t div0(big_t n, big_t d);
    if (d == 0) return 0;
    return n / d;
  endfunction

  function automatic logic [31:0] clamp_s32(big_t x);
    if (x > big_t'(32'sh7FFFFFFF)) return 32'h7FFFFFFF;
    if (x < -big_t'(64'sh80000000)) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic answer_t solve_intercept(query_t q, logic [30:0] spd);
    big_t px, py, vx, vy, s, a, b, c, d, t, r, f, t1, t2, tq;
    answer_t ans;
    px = q.px; py = q.py; vx = q.vx; vy = q.vy;
    s = {225'b0, spd};
    a = vx * vx + vy * vy - s * s;
    b = px * vx + py * vy;
    c = px * px + py * py;
    d = b * b - a * c;
    t = 0;
    if (d <= 0) begin
      if (a == 0) begin
        ans.oc = OUTCOME_DEGEN;
      end else begin
        t = div0((-b) <<< FRAC_BITS, a);
        ans.oc = OUTCOME_CLOSEST;
      end
    end else begin
      r = floor_sqrt(d);
      f = (b > 0) ? -(b + r) : r - b;
      ans.oc = OUTCOME_ROOT;
      if (a == 0 || ((f < 0) != (a < 0))) begin
        t = div0(c <<< FRAC_BITS, f);
      end else if (c == 0 || f < 0) begin
        t = div0(f <<< FRAC_BITS, a);
      end else begin
        t1 = div0(f <<< FRAC_BITS, a);
        t2 = div0(c <<< FRAC_BITS, f);
        t = (t2 < t1) ? t2 : t1;
      end
    end
    if (t < 0) tq = 0;
    else if (t > big_t'(33'h0FFFFFFFF)) tq = big_t'(33'h0FFFFFFFF);
    else tq = t;
    ans.t  = tq[31:0];
    ans.ax = clamp_s32(px + ((tq * vx) >>> FRAC_BITS));
    ans.ay = clamp_s32(py + ((tq * vy) >>> FRAC_BITS));
    return ans;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Driver: holds a word until it is taken, then pulls the next one.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_answers.push_back(solve_intercept(
          '{rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y}, shot_speed));
        accepted++;
      end
      if (!(start && busy)) begin
        if (pending_queries.size() > 0 && $urandom_range(99) >= idle_pct) begin
          query_t q;
          q = pending_queries.pop_front();
          rel_pos_x <= q.px;
          rel_pos_y <= q.py;
          rel_vel_x <= q.vx;
          rel_vel_y <= q.vy;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest expected word.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result aim=(%h,%h) t=%h oc=%0d", $time,
                 aim_x, aim_y, hit_time, outcome);
        errors++;
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        checked++;
        case (e.oc)
          OUTCOME_ROOT:    cnt_root++;
          OUTCOME_CLOSEST: cnt_closest++;
          default:         cnt_degen++;
        endcase
        if (aim_x !== e.ax) begin
          $display("%0t: aim_x expected %h actual %h", $time, e.ax, aim_x);
          errors++;
        end
        if (aim_y !== e.ay) begin
          $display("%0t: aim_y expected %h actual %h", $time, e.ay, aim_y);
          errors++;
        end
        if (hit_time !== e.t) begin
          $display("%0t: hit_time expected %h actual %h", $time, e.t, hit_time);
          errors++;
        end
        if (outcome !== e.oc) begin
          $display("%0t: outcome expected %0d actual %0d", $time, e.oc, outcome);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0, 1:    return v;
      2:       return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $signed(v) >>> $urandom_range(20, 8);
    endcase
  endfunction

  task automatic add_query(logic [31:0] px, py, vx, vy);
    query_t q;
    q.px = px; q.py = py; q.vx = vx; q.vy = vy;
    pending_queries.push_back(q);
  endtask

  task automatic wait_drained();
    while (pending_queries.size() > 0 || start || expected_answers.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_speed(logic [30:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shot_speed = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [30:0] speeds[7];
    int pcts[4];
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    rel_pos_x = '0; rel_pos_y = '0; rel_vel_x = '0; rel_vel_y = '0;
    shot_speed = SPEED_RESET;
    idle_pct = 0;
    errors = 0; accepted = 0; checked = 0;
    cnt_root = 0; cnt_closest = 0; cnt_degen = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset speed of 1.0.
    add_query(0, 0, 32'h00010000, 0);
    add_query(0, 0, 0, 32'hFFFF0000);
    add_query(0, 0, 0, 0);
    add_query(32'h00050000, 0, 0, 0);
    add_query(32'h00050000, 32'hFFFD0000, 32'h00008000, 0);
    add_query(32'h00050000, 0, 32'h00030000, 0);
    add_query(32'h00050000, 0, 32'hFFFD0000, 0);
    add_query(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    add_query(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    add_query(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_query(32'h00000001, 0, 32'h00000001, 0);
    add_query(32'h7FFFFFFF, 0, 32'h00000001, 0);
    add_query(32'h00010000, 32'h00010000, 32'hFFFF8000, 32'h00002000);
    wait_drained();

    speeds = '{31'h0, 31'h7FFFFFFF, 31'h00010000, 31'h00000001,
               31'h00040000, 31'h00002000, 31'h0};
    speeds[6] = 31'($urandom);
    pcts = '{0, 69, 28, 0};
    for (int ph = 0; ph < 7; ph++) begin
      write_speed(speeds[ph]);
      idle_pct = pcts[ph % 4];
      if (ph == 0) add_query(0, 0, 0, 0);
      for (int i = 0; i < 100; i++)
        add_query(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      wait_drained();
    end

    $display("Sent %0d words over 8 speed settings; %0d checked:", accepted, checked);
    $display("%0d root, %0d closest, %0d degenerate", cnt_root, cnt_closest, cnt_degen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tis_pkg.sv
rtl/tis_sqrt_cell.sv
rtl/tis_div_cell.sv
rtl/target_intercept_solver.sv
sim/tb_target_intercept_solver.sv
